>>> hdl/acd_pkg.sv
// Package for the archive container deframer: phase, label and status codes,
// the result record passed from the parser to the output buffer.
// No dependencies.
`default_nettype none

package acd_pkg;

    localparam logic [31:0] MAGIC_RESET = 32'h504B0304;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_COUNT,
        PH_NAMELEN,
        PH_NAME,
        PH_SIZE,
        PH_CONTENT,
        PH_DONE,
        PH_ERROR
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER,
        KIND_NAME,
        KIND_CONTENT,
        KIND_IGNORED
    } t_kind;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_MAGIC,
        ST_SHORT,
        ST_TRUNC,
        ST_OK
    } t_status;

    typedef struct packed {
        logic [7:0]  byte_out;
        t_kind       byte_kind;
        logic        name_end;
        logic        file_done;
        logic [31:0] file_index;
        logic [31:0] content_length;
        t_status     parse_status;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/archive_container_deframer_core.sv
// Archive container deframer, top level: input handshake, magic register and
// a two-entry output buffer around acd_parser. Depends on acd_pkg, acd_parser.
//
// Takes an archive one byte per request (tlast marks the final byte of the
// buffer) and returns one labelled byte per request: kind on m_axis_tuser,
// file-done on m_axis_tlast, the rest in m_axis_tdata. One byte is accepted
// every clock cycle while the skid entry is empty; the rate is set by the
// parser, which updates its phase, counters and shift registers on each byte.
// Results are registered; the skid entry keeps one byte accepted in a stall.
// After a final byte the parser returns to its reset state; the magic register
// keeps its value. Write the magic only while the block is idle.
`default_nettype none

module archive_container_deframer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wen,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // final_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] byte_out, [8] name_end, [40:9] file_index,
    // [72:41] content_length, [75:73] parse_status, [79:76] zero
    output logic [79:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser,   // [1:0] byte_kind
    output logic             m_axis_tlast    // file_done
);

    logic [31:0]      r_magic;
    logic             w_accept;
    acd_pkg::t_result w_result;
    acd_pkg::t_result r_out, r_skid;
    logic             r_out_valid, r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= acd_pkg::MAGIC_RESET;
        end else if (i_cfg_wen) begin
            r_magic <= i_cfg_wdata;
        end
    end

    assign s_axis_tready = !r_skid_valid;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    acd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_accept),
        .i_data   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_magic  (r_magic),
        .o_result (w_result)
    );

    // output register with a skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_axis_tready) begin
            r_out <= r_skid_valid ? r_skid : w_result;
        end
        if (r_out_valid && !m_axis_tready && w_accept) begin
            r_skid <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out.parse_status, r_out.content_length,
                            r_out.file_index, r_out.name_end, r_out.byte_out};
    assign m_axis_tuser  = r_out.byte_kind;
    assign m_axis_tlast  = r_out.file_done;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready && w_accept) |=> r_skid_valid)
        else $error("request accepted under stall not kept in skid entry");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && m_axis_tready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry not moved to output register");
`endif

endmodule

`default_nettype wire

>>> hdl/acd_parser.sv
// Byte-at-a-time archive parser: phase/counter state and the labelling of
// each request. Depends on acd_pkg.
`default_nettype none

module acd_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic [7:0]      i_data,
    input  wire logic            i_last,
    input  wire logic [31:0]     i_magic,
    output acd_pkg::t_result     o_result
);

    acd_pkg::t_phase  r_phase, n_phase;
    logic [1:0]       r_idx, n_idx;
    logic [31:0]      r_bytes_left, n_bytes_left;
    logic [31:0]      r_files_left, n_files_left;
    logic [31:0]      r_file, n_file;
    logic [31:0]      r_size, n_size;
    acd_pkg::t_status r_status, n_status;

    logic             w_finish;
    logic [7:0]       w_magic_byte;

    // magic is compared most significant byte first
    always_comb begin
        case (r_idx)
            2'd0:    w_magic_byte = i_magic[31:24];
            2'd1:    w_magic_byte = i_magic[23:16];
            2'd2:    w_magic_byte = i_magic[15:8];
            default: w_magic_byte = i_magic[7:0];
        endcase
    end

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_idx        = r_idx;
        n_bytes_left = r_bytes_left;
        n_files_left = r_files_left;
        n_file       = r_file;
        n_size       = r_size;
        n_status     = r_status;
        w_finish     = 1'b0;
        case (r_phase)
            acd_pkg::PH_MAGIC: begin
                if (i_data != w_magic_byte) begin
                    n_phase  = acd_pkg::PH_ERROR;
                    n_status = acd_pkg::ST_MAGIC;
                end else if (r_idx == 2'd3) begin
                    n_idx   = 2'd0;
                    n_phase = acd_pkg::PH_COUNT;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            acd_pkg::PH_COUNT: begin
                n_files_left = {r_files_left[23:0], i_data};
                if (r_idx == 2'd3) begin
                    n_idx = 2'd0;
                    if (n_files_left == 32'd0) begin
                        n_phase  = acd_pkg::PH_DONE;
                        n_status = acd_pkg::ST_OK;
                    end else begin
                        n_phase = acd_pkg::PH_NAMELEN;
                    end
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            acd_pkg::PH_NAMELEN: begin
                n_bytes_left = {16'd0, r_bytes_left[7:0], i_data};
                if (r_idx != 2'd0) begin
                    n_idx   = 2'd0;
                    n_size  = 32'd0;
                    n_phase = (n_bytes_left == 32'd0) ? acd_pkg::PH_SIZE : acd_pkg::PH_NAME;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            acd_pkg::PH_NAME: begin
                n_bytes_left = r_bytes_left - 32'd1;
                if (r_bytes_left == 32'd1) begin
                    n_phase = acd_pkg::PH_SIZE;
                end
            end
            acd_pkg::PH_SIZE: begin
                n_size = {r_size[23:0], i_data};
                if (r_idx == 2'd3) begin
                    n_idx = 2'd0;
                    if (n_size == 32'd0) begin
                        w_finish = 1'b1;
                    end else begin
                        n_bytes_left = n_size;
                        n_phase      = acd_pkg::PH_CONTENT;
                    end
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            acd_pkg::PH_CONTENT: begin
                n_bytes_left = r_bytes_left - 32'd1;
                if (r_bytes_left == 32'd1) begin
                    w_finish = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (w_finish) begin
            n_files_left = r_files_left - 32'd1;
            n_file       = r_file + 32'd1;
            if (r_files_left == 32'd1) begin
                n_phase  = acd_pkg::PH_DONE;
                n_status = acd_pkg::ST_OK;
            end else begin
                n_phase = acd_pkg::PH_NAMELEN;
            end
        end

        // end of buffer before the archive closed
        if (i_last && n_status == acd_pkg::ST_RUN) begin
            n_status = (n_phase == acd_pkg::PH_MAGIC || n_phase == acd_pkg::PH_COUNT)
                       ? acd_pkg::ST_SHORT : acd_pkg::ST_TRUNC;
        end
    end

    // outputs
    always_comb begin
        o_result.byte_out     = i_data;
        o_result.name_end     = (r_phase == acd_pkg::PH_NAME) && (r_bytes_left == 32'd1);
        o_result.file_done    = w_finish;
        o_result.file_index   = r_file;
        o_result.parse_status = n_status;
        case (r_phase)
            acd_pkg::PH_MAGIC, acd_pkg::PH_COUNT, acd_pkg::PH_NAMELEN: begin
                o_result.byte_kind      = acd_pkg::KIND_HEADER;
                o_result.content_length = 32'd0;
            end
            acd_pkg::PH_SIZE: begin
                o_result.byte_kind      = acd_pkg::KIND_HEADER;
                o_result.content_length = (r_idx == 2'd3) ? n_size : 32'd0;
            end
            acd_pkg::PH_NAME: begin
                o_result.byte_kind      = acd_pkg::KIND_NAME;
                o_result.content_length = 32'd0;
            end
            acd_pkg::PH_CONTENT: begin
                o_result.byte_kind      = acd_pkg::KIND_CONTENT;
                o_result.content_length = r_size;
            end
            default: begin
                o_result.byte_kind      = acd_pkg::KIND_IGNORED;
                o_result.content_length = 32'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_phase      <= acd_pkg::PH_MAGIC;
            r_idx        <= 2'd0;
            r_bytes_left <= 32'd0;
            r_files_left <= 32'd0;
            r_file       <= 32'd0;
            r_size       <= 32'd0;
            r_status     <= acd_pkg::ST_RUN;
        end else if (i_en) begin
            r_phase      <= n_phase;
            r_idx        <= n_idx;
            r_bytes_left <= n_bytes_left;
            r_files_left <= n_files_left;
            r_file       <= n_file;
            r_size       <= n_size;
            r_status     <= n_status;
        end
    end

`ifndef SYNTHESIS
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_last) |=> (r_phase == acd_pkg::PH_MAGIC && r_status == acd_pkg::ST_RUN))
        else $error("state not cleared after final byte");

    a_ok_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status == acd_pkg::ST_OK) == (r_phase == acd_pkg::PH_DONE))
        else $error("complete status and done phase disagree");

    a_magic_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status == acd_pkg::ST_MAGIC) == (r_phase == acd_pkg::PH_ERROR))
        else $error("bad magic status and error phase disagree");
`endif

endmodule

`default_nettype wire
